FILE: rtl/core/fbsd_pkg.sv
// ----------------------------------------------------------------------------
// fbsd_pkg
// shared constants and types for the frame buffer shape drawer
// ----------------------------------------------------------------------------
package fbsd_pkg;

	localparam int SCREEN_WIDTH_DEF  = 128;
	localparam int SCREEN_HEIGHT_DEF = 128;

	localparam int MODE_W  = 3;
	localparam int POS_W   = 10;
	localparam int SIZE_W  = 8;
	localparam int RAD_W   = 7;
	localparam int COLOR_W = 16;

	// internal coordinate width, wide enough for edge plus size
	localparam int COORD_W = 12;
	// squared distance width
	localparam int DIST_W  = 16;

	typedef logic [MODE_W-1:0]          mode_t;
	typedef logic signed [POS_W-1:0]    pos_t;
	typedef logic [SIZE_W-1:0]          size_t;
	typedef logic [RAD_W-1:0]           rad_t;
	typedef logic [COLOR_W-1:0]         color_t;
	typedef logic signed [COORD_W-1:0]  coord_t;
	typedef logic [DIST_W-1:0]          dist_t;

	localparam mode_t MODE_CLEAR  = 3'd0;
	localparam mode_t MODE_PLOT   = 3'd1;
	localparam mode_t MODE_RECT   = 3'd2;
	localparam mode_t MODE_CIRCLE = 3'd3;
	localparam mode_t MODE_READ   = 3'd4;

endpackage

FILE: rtl/core/fbsd_store.sv
// ----------------------------------------------------------------------------
// fbsd_store
// single-port-write, single-port-read frame store with registered read data
// ----------------------------------------------------------------------------
module fbsd_store #(
	parameter int DEPTH = fbsd_pkg::SCREEN_WIDTH_DEF * fbsd_pkg::SCREEN_HEIGHT_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                   clk,
	input  logic                   we,
	input  logic [AW-1:0]          waddr,
	input  fbsd_pkg::color_t       wdata,
	input  logic                   re,
	input  logic [AW-1:0]          raddr,
	output fbsd_pkg::color_t       rdata
);
	import fbsd_pkg::*;

	color_t mem_q [DEPTH];
	color_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/core/framebuffer_shape_drawer.sv
// ----------------------------------------------------------------------------
// framebuffer_shape_drawer
// RGB565 frame store with clear, plot, rectangle, circle and read commands
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. Every drawing
// command scans its bounding box, clipped to the screen, one pixel per clock
// through the single write port of the frame store, so busy stays high while
// the clipped box is scanned and for one ST_DRAIN state after it; busy does
// not rise when the shape lies fully off screen. A read passes through ST_RD
// and puts pixel_color on the bus in ST_RD_OUT with done high for exactly
// one cycle; the receiver cannot stall it, so it must sample on that cycle.
// Out-of-screen reads return zero. The store is not cleared by reset; clear
// it before reading.
module framebuffer_shape_drawer #(
	parameter int SCREEN_WIDTH  = fbsd_pkg::SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = fbsd_pkg::SCREEN_HEIGHT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  fbsd_pkg::mode_t    mode,
	input  fbsd_pkg::pos_t     x_pos,
	input  fbsd_pkg::pos_t     y_pos,
	input  fbsd_pkg::size_t    rect_width,
	input  fbsd_pkg::size_t    rect_height,
	input  fbsd_pkg::rad_t     radius,
	input  fbsd_pkg::color_t   color,
	input  logic               filled,
	output logic               done,
	output fbsd_pkg::color_t   pixel_color
);
	import fbsd_pkg::*;

	localparam int DEPTH = SCREEN_WIDTH * SCREEN_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int XW    = $clog2(SCREEN_WIDTH);
	localparam int YW    = $clog2(SCREEN_HEIGHT);
	localparam coord_t XMAX = COORD_W'(SCREEN_WIDTH - 1);
	localparam coord_t YMAX = COORD_W'(SCREEN_HEIGHT - 1);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SCAN   = 3'd1;
	localparam logic [2:0] ST_DRAIN  = 3'd2;
	localparam logic [2:0] ST_RD     = 3'd3;
	localparam logic [2:0] ST_RD_OUT = 3'd4;

	logic [2:0] state_q;

	// command registers
	mode_t           mode_q;
	color_t          color_q;
	logic            filled_q;
	logic            rd_ok_q;
	coord_t          x0_q, x1_q, y0_q, y1_q;
	logic [XW-1:0]   i0_q, i1_q, i_q;
	logic [YW-1:0]   j1_q, j_q;
	dist_t           rr_q, lo_q, hi_q;

	// write pipeline
	logic            v_s1;
	logic [AW-1:0]   addr_s1;
	dist_t           dx2_s1, dy2_s1;
	logic            hit_s1;
	logic            circ_s1;

	// accept-cycle box computation
	coord_t xs, ys, wext, hext, rext;
	coord_t bx0, bx1, by0, by1, cx0, cx1, cy0, cy1;
	logic   draw_mode, box_ok, rd_in;
	logic   accept;
	logic [RAD_W:0] rm1, rp1;

	always_comb begin
		xs   = {{(COORD_W-POS_W){x_pos[POS_W-1]}}, x_pos};
		ys   = {{(COORD_W-POS_W){y_pos[POS_W-1]}}, y_pos};
		wext = {{(COORD_W-SIZE_W){1'b0}}, rect_width};
		hext = {{(COORD_W-SIZE_W){1'b0}}, rect_height};
		rext = {{(COORD_W-RAD_W){1'b0}}, radius};
		draw_mode = 1'b1;
		bx0 = xs;
		bx1 = xs;
		by0 = ys;
		by1 = ys;
		unique case (mode)
			MODE_CLEAR: begin
				bx0 = '0;
				bx1 = XMAX;
				by0 = '0;
				by1 = YMAX;
			end
			MODE_PLOT: begin
				bx0 = xs;
			end
			MODE_RECT: begin
				bx1 = xs + wext - COORD_W'(1);
				by1 = ys + hext - COORD_W'(1);
			end
			MODE_CIRCLE: begin
				bx0 = xs - rext;
				bx1 = xs + rext;
				by0 = ys - rext;
				by1 = ys + rext;
			end
			default: begin
				draw_mode = 1'b0;
			end
		endcase
		cx0 = bx0[COORD_W-1] ? '0 : bx0;
		cy0 = by0[COORD_W-1] ? '0 : by0;
		cx1 = (bx1 > XMAX) ? XMAX : bx1;
		cy1 = (by1 > YMAX) ? YMAX : by1;
		box_ok = draw_mode && (cx0 <= cx1) && (cy0 <= cy1);
		rd_in  = !xs[COORD_W-1] && (xs <= XMAX) && !ys[COORD_W-1] && (ys <= YMAX);
		rm1 = (radius == '0) ? (RAD_W+1)'(1) : (RAD_W+1)'(radius) - (RAD_W+1)'(1);
		rp1 = (RAD_W+1)'(radius) + (RAD_W+1)'(1);
	end

	assign accept = start && !busy;
	assign busy   = (state_q != ST_IDLE);

	// scan-cycle pixel tests
	coord_t          ii, jj, dxw, dyw;
	logic signed [7:0] dx8, dy8;
	logic signed [15:0] dxp, dyp;
	logic [AW-1:0]   addr_c;
	logic            pre_hit;

	always_comb begin
		ii  = {{(COORD_W-XW){1'b0}}, i_q};
		jj  = {{(COORD_W-YW){1'b0}}, j_q};
		dxw = ii - x0_q;
		dyw = jj - y0_q;
		dx8 = dxw[7:0];
		dy8 = dyw[7:0];
		dxp = dx8 * dx8;
		dyp = dy8 * dy8;
		addr_c = AW'(j_q * SCREEN_WIDTH) + AW'(i_q);
		pre_hit = (mode_q != MODE_RECT) || filled_q || (ii == x0_q) || (ii == x1_q)
			|| (jj == y0_q) || (jj == y1_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			v_s1    <= 1'b0;
		end else begin
			v_s1 <= (state_q == ST_SCAN);
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (mode == MODE_READ) begin
							state_q <= ST_RD;
						end else if (box_ok) begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (i_q == i1_q && j_q == j1_q) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN:  state_q <= ST_IDLE;
				ST_RD:     state_q <= ST_RD_OUT;
				ST_RD_OUT: state_q <= ST_IDLE;
				default:   state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q   <= mode;
			color_q  <= color;
			filled_q <= filled;
			rd_ok_q  <= rd_in;
			x0_q     <= xs;
			y0_q     <= ys;
			x1_q     <= xs + wext - COORD_W'(1);
			y1_q     <= ys + hext - COORD_W'(1);
			rr_q     <= DIST_W'(radius) * DIST_W'(radius);
			lo_q     <= DIST_W'(rm1) * DIST_W'(rm1);
			hi_q     <= DIST_W'(rp1) * DIST_W'(rp1);
			if (mode == MODE_READ) begin
				i_q <= xs[XW-1:0];
				j_q <= ys[YW-1:0];
			end else begin
				i_q <= cx0[XW-1:0];
				j_q <= cy0[YW-1:0];
			end
			i0_q <= cx0[XW-1:0];
			i1_q <= cx1[XW-1:0];
			j1_q <= cy1[YW-1:0];
		end else if (state_q == ST_SCAN) begin
			if (i_q == i1_q) begin
				i_q <= i0_q;
				j_q <= j_q + YW'(1);
			end else begin
				i_q <= i_q + XW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= addr_c;
		dx2_s1  <= dxp;
		dy2_s1  <= dyp;
		hit_s1  <= pre_hit;
		circ_s1 <= (mode_q == MODE_CIRCLE);
	end

	// write stage
	dist_t d_s1;
	logic  circ_hit, we;
	color_t rdata;

	always_comb begin
		d_s1 = dx2_s1 + dy2_s1;
		circ_hit = filled_q ? (d_s1 <= rr_q) : ((d_s1 >= lo_q) && (d_s1 <= hi_q));
		we = v_s1 && (circ_s1 ? circ_hit : hit_s1);
	end

	fbsd_store #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (addr_s1),
		.wdata (color_q),
		.re    (state_q == ST_RD),
		.raddr (addr_c),
		.rdata (rdata)
	);

	assign done        = (state_q == ST_RD_OUT);
	assign pixel_color = (done && rd_ok_q) ? rdata : '0;

	// writes only follow a scan cycle
	a_we_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> $past(state_q) == ST_SCAN)
		else $error("store write outside a scan");

	// no transaction is taken while a pixel write is pending
	a_no_accept_pending: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> !v_s1)
		else $error("transaction taken with pending write");

	// a result follows a read transaction taken in ST_IDLE, after the ST_RD state
	a_done_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q, 2) == ST_IDLE && $past(mode_q) == MODE_READ)
		else $error("result without read transaction");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done && !busy)
		else $error("result strobe longer than one cycle");

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// drives clear, plot, rectangle, circle and read commands into the frame
// buffer shape drawer, mirrors every pixel write in a local copy of the frame
// store and compares each read transaction against that copy
// ----------------------------------------------------------------------------
module testbench;

	import fbsd_pkg::*;

	localparam int SCREEN_W    = SCREEN_WIDTH_DEF;
	localparam int SCREEN_H    = SCREEN_HEIGHT_DEF;
	localparam int STORE_WORDS = SCREEN_W * SCREEN_H;

	localparam mode_t MODE_SPARE_FIRST = 3'd5;
	localparam mode_t MODE_SPARE_LAST  = 3'd7;

	localparam int RANDOM_CMDS   = 100;
	localparam int RANDOM_READS  = 40;
	localparam int MAX_GAP       = 40;
	localparam int DRAIN_CYCLES  = 20;
	localparam int ITEM_BOUND    = 300;
	localparam int CYCLE_LIMIT   = 4 * ITEM_BOUND * (STORE_WORDS + MAX_GAP + 8);

	typedef struct {
		mode_t  mode;
		pos_t   x;
		pos_t   y;
		size_t  w;
		size_t  h;
		rad_t   r;
		color_t c;
		logic   fill;
	} draw_cmd_t;

	class draw_scoreboard;
		color_t pixels [STORE_WORDS];
		color_t pending_reads [$];
		int     errors;

		function void set_pixel(int px, int py, color_t c);
			if (px >= 0 && px < SCREEN_W && py >= 0 && py < SCREEN_H)
				pixels[py * SCREEN_W + px] = c;
		endfunction

		function void note_command(draw_cmd_t cmd);
			int x0;
			int y0;
			int wd;
			int ht;
			int rr;
			int d;
			int lo;
			int hi;
			x0 = int'(cmd.x);
			y0 = int'(cmd.y);
			wd = int'(cmd.w);
			ht = int'(cmd.h);
			rr = int'(cmd.r);
			case (cmd.mode)
				MODE_CLEAR: begin
					foreach (pixels[k])
						pixels[k] = cmd.c;
				end
				MODE_PLOT: begin
					set_pixel(x0, y0, cmd.c);
				end
				MODE_RECT: begin
					for (int j = (y0 < 0 ? 0 : y0); j < y0 + ht && j < SCREEN_H; j++)
						for (int i = (x0 < 0 ? 0 : x0); i < x0 + wd && i < SCREEN_W; i++)
							if (cmd.fill || j == y0 || j == y0 + ht - 1 ||
									i == x0 || i == x0 + wd - 1)
								set_pixel(i, j, cmd.c);
				end
				MODE_CIRCLE: begin
					lo = (rr - 1) * (rr - 1);
					hi = (rr + 1) * (rr + 1);
					for (int dy = -rr; dy <= rr; dy++)
						for (int dx = -rr; dx <= rr; dx++) begin
							d = dx * dx + dy * dy;
							if (cmd.fill ? (d <= rr * rr) : (d >= lo && d <= hi))
								set_pixel(x0 + dx, y0 + dy, cmd.c);
						end
				end
				MODE_READ: begin
					if (x0 < 0 || x0 >= SCREEN_W || y0 < 0 || y0 >= SCREEN_H)
						pending_reads.push_back('0);
					else
						pending_reads.push_back(pixels[y0 * SCREEN_W + x0]);
				end
				default: ;
			endcase
		endfunction

		function void check_read(color_t got);
			color_t want;
			if (pending_reads.size() == 0) begin
				$error("pixel_color: no read pending, expected none actual %h", got);
				errors++;
			end else begin
				want = pending_reads.pop_front();
				if (got !== want) begin
					$error("pixel_color: expected %h actual %h", want, got);
					errors++;
				end
			end
		endfunction
	endclass

	logic   clk = 1'b0;
	logic   arst_n;
	logic   start;
	logic   busy;
	mode_t  mode;
	pos_t   x_pos;
	pos_t   y_pos;
	size_t  rect_width;
	size_t  rect_height;
	rad_t   radius;
	color_t color;
	logic   filled;
	logic   done;
	color_t pixel_color;

	draw_scoreboard sb;
	int             cycles = 0;

	framebuffer_shape_drawer dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.mode        (mode),
		.x_pos       (x_pos),
		.y_pos       (y_pos),
		.rect_width  (rect_width),
		.rect_height (rect_height),
		.radius      (radius),
		.color       (color),
		.filled      (filled),
		.done        (done),
		.pixel_color (pixel_color)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("testbench failed");
			$finish;
		end
	end

	// read results cannot be held off, so every strobe is checked at once
	always @(posedge clk) begin
		if (arst_n === 1'b1 && done === 1'b1)
			sb.check_read(pixel_color);
	end

	function automatic draw_cmd_t cmd_of(mode_t m, int x, int y, int w, int h, int r,
			int c, bit f);
		draw_cmd_t cmd;
		cmd.mode = m;
		cmd.x    = pos_t'(x);
		cmd.y    = pos_t'(y);
		cmd.w    = size_t'(w);
		cmd.h    = size_t'(h);
		cmd.r    = rad_t'(r);
		cmd.c    = color_t'(c);
		cmd.fill = f;
		return cmd;
	endfunction

	// mostly near the screen, sometimes anywhere in the field range
	function automatic int pick_pos();
		if ($urandom_range(99) < 80)
			return int'($urandom_range(SCREEN_W + 15)) - 8;
		return int'($urandom_range(1023)) - 512;
	endfunction

	// mostly small, a few up to the field maximum
	function automatic int pick_span(int small_max, int full_max);
		if ($urandom_range(99) < 5)
			return int'($urandom_range(full_max));
		return int'($urandom_range(small_max));
	endfunction

	task automatic issue(input draw_cmd_t cmd, input int idle_pct);
		int gap;
		gap = 0;
		@(negedge clk);
		while (gap < MAX_GAP && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			gap++;
			@(negedge clk);
		end
		mode        <= cmd.mode;
		x_pos       <= cmd.x;
		y_pos       <= cmd.y;
		rect_width  <= cmd.w;
		rect_height <= cmd.h;
		radius      <= cmd.r;
		color       <= cmd.c;
		filled      <= cmd.fill;
		start       <= 1'b1;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
		sb.note_command(cmd);
	endtask

	initial begin
		draw_cmd_t cmd;
		int        n_cmds;
		int        n_reads;
		int        pick;
		int        idle_pct;

		sb          = new;
		arst_n      = 1'b0;
		start       = 1'b0;
		mode        = MODE_CLEAR;
		x_pos       = '0;
		y_pos       = '0;
		rect_width  = '0;
		rect_height = '0;
		radius      = '0;
		color       = '0;
		filled      = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// store is undefined after reset, so clear comes first
		issue(cmd_of(MODE_CLEAR, 0, 0, 0, 0, 0, 16'h0000, 1'b0), 0);
		issue(cmd_of(MODE_READ, 0, 0, 0, 0, 0, 0, 1'b0), 0);
		issue(cmd_of(MODE_PLOT, 0, 0, 0, 0, 0, 16'hFFFF, 1'b1), 0);
		issue(cmd_of(MODE_PLOT, SCREEN_W - 1, SCREEN_H - 1, 255, 255, 127, 16'h5AA5, 1'b0), 0);
		issue(cmd_of(MODE_PLOT, -1, 5, 0, 0, 0, 16'h1234, 1'b0), 0);
		issue(cmd_of(MODE_PLOT, 5, -512, 0, 0, 0, 16'h1234, 1'b0), 0);
		issue(cmd_of(MODE_PLOT, 511, SCREEN_H, 0, 0, 0, 16'h1234, 1'b0), 0);
		issue(cmd_of(MODE_READ, 0, 0, 0, 0, 0, 0, 1'b0), 0);
		issue(cmd_of(MODE_READ, SCREEN_W - 1, SCREEN_H - 1, 0, 0, 0, 0, 1'b0), 0);
		issue(cmd_of(MODE_READ, -1, 5, 0, 0, 0, 0, 1'b0), 0);
		issue(cmd_of(MODE_READ, SCREEN_W, 0, 0, 0, 0, 0, 1'b0), 0);
		issue(cmd_of(MODE_READ, 0, -512, 0, 0, 0, 0, 1'b0), 0);
		issue(cmd_of(MODE_READ, 511, 511, 255, 255, 127, 16'hFFFF, 1'b1), 0);
		issue(cmd_of(MODE_RECT, -3, -3, 8, 8, 0, 16'h07E0, 1'b1), 0);
		issue(cmd_of(MODE_RECT, 100, 110, 255, 255, 0, 16'hF800, 1'b0), 0);
		issue(cmd_of(MODE_RECT, 20, 20, 0, 9, 0, 16'hABCD, 1'b1), 0);
		issue(cmd_of(MODE_RECT, 20, 20, 9, 0, 0, 16'hABCD, 1'b0), 0);
		issue(cmd_of(MODE_CIRCLE, 64, 64, 0, 0, 0, 16'h001F, 1'b1), 0);
		issue(cmd_of(MODE_CIRCLE, 10, 10, 0, 0, 0, 16'hFFFF, 1'b0), 0);
		issue(cmd_of(MODE_CIRCLE, 64, 64, 0, 0, 127, 16'h8410, 1'b0), 0);
		issue(cmd_of(MODE_CIRCLE, 0, SCREEN_H - 1, 0, 0, 6, 16'h7BEF, 1'b1), 0);
		issue(cmd_of(MODE_SPARE_FIRST, 3, 3, 4, 4, 4, 16'hDEAD, 1'b1), 0);
		issue(cmd_of(MODE_SPARE_LAST, 3, 3, 4, 4, 4, 16'hBEEF, 1'b0), 0);
		issue(cmd_of(MODE_READ, 64, 64, 0, 0, 0, 0, 1'b0), 0);
		issue(cmd_of(MODE_READ, 3, 3, 0, 0, 0, 0, 1'b0), 0);

		n_cmds  = 0;
		n_reads = 0;
		while (n_cmds < RANDOM_CMDS || n_reads < RANDOM_READS) begin
			case ((n_cmds / 25) % 4)
				1:       idle_pct = 82;
				3:       idle_pct = 10;
				default: idle_pct = 0;
			endcase
			cmd.x    = pos_t'(pick_pos());
			cmd.y    = pos_t'(pick_pos());
			cmd.w    = size_t'(pick_span(24, 255));
			cmd.h    = size_t'(pick_span(24, 255));
			cmd.r    = rad_t'(pick_span(12, 127));
			cmd.c    = color_t'($urandom_range(16'hFFFF));
			cmd.fill = 1'($urandom_range(1));
			pick     = $urandom_range(99);
			if (pick < 40)
				cmd.mode = MODE_READ;
			else if (pick < 60)
				cmd.mode = MODE_PLOT;
			else if (pick < 77)
				cmd.mode = MODE_RECT;
			else if (pick < 94)
				cmd.mode = MODE_CIRCLE;
			else if (pick < 96)
				cmd.mode = MODE_CLEAR;
			else
				cmd.mode = mode_t'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST));
			issue(cmd, idle_pct);
			if (cmd.mode == MODE_READ)
				n_reads++;
			if (cmd.mode <= MODE_READ)
				n_cmds++;
		end

		@(negedge clk);
		start <= 1'b0;
		while (sb.pending_reads.size() != 0)
			@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.errors == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule

FILE: framebuffer_shape_drawer.f
rtl/core/fbsd_pkg.sv
rtl/core/fbsd_store.sv
rtl/core/framebuffer_shape_drawer.sv
test/testbench.sv
